>>> hw/rtl/tftpc_pkg.sv
// Shared types and codes for the TFTP client transfer control block.
// No dependencies; every other file in hw/rtl refers to this package.
package tftpc_pkg;

    // Event kinds
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PACKET  = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // TFTP opcodes the block acts on
    localparam logic [15:0] PKT_DATA  = 16'd3;
    localparam logic [15:0] PKT_ACK   = 16'd4;
    localparam logic [15:0] PKT_ERROR = 16'd5;
    localparam logic [15:0] PKT_OACK  = 16'd6;

    // ERROR packet codes with a status of their own
    localparam logic [15:0] ERR_NOT_FOUND = 16'd1;
    localparam logic [15:0] ERR_DENIED    = 16'd2;

    // Actions
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_REQ  = 2'd1;
    localparam logic [1:0] SEND_ACK  = 2'd2;
    localparam logic [1:0] SEND_DATA = 2'd3;

    // Completion status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DENIED    = 3'd3;
    localparam logic [2:0] ST_OTHER     = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_TRANSFER_MODE  = 3'd0;
    localparam logic [2:0] CFG_FILE_LENGTH    = 3'd1;
    localparam logic [2:0] CFG_BUFFER_BASE    = 3'd2;
    localparam logic [2:0] CFG_RETRY_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_PROPOSED_BSIZE = 3'd4;

    // Register reset values
    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd5;
    localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;

    // Transfer mode values
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'b01,
        PH_ACTIVE = 2'b10
    } phase_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] packet_opcode;
        logic [15:0] block_number;
        logic [15:0] payload_length;
        logic [15:0] error_code;
        logic        option_is_block_size;
        logic [15:0] option_block_size;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_block;
        logic [31:0] send_address;
        logic [15:0] send_length;
        logic        store_enable;
        logic [31:0] store_address;
        logic        finished;
        logic [2:0]  status;
        logic [31:0] received_length;
    } out_word_t;

    // Configuration write as it travels from the port to the engine
    typedef struct packed {
        logic        write;
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_write_t;

endpackage

>>> hw/rtl/tftpc_in_stage.sv
// Input register of the TFTP client transfer control block.
// Depends on tftpc_pkg for the input word type.
module tftpc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tftpc_pkg::in_word_t  in_word,
    output logic                 item_valid,
    output tftpc_pkg::in_word_t  item,
    input  logic                 item_take
);

    logic                valid_reg;
    logic                valid_next;
    tftpc_pkg::in_word_t word_reg;

    // Stall only while a held word cannot move on this cycle
    assign in_stall   = valid_reg && !item_take;
    assign item_valid = valid_reg;
    assign item       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new word whenever the register is free
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            word_reg <= in_word;
        end
    end

endmodule

>>> hw/rtl/tftpc_engine.sv
// Transfer state, configuration registers and the single-pass event logic.
// Depends on tftpc_pkg for codes, the word types and the configuration struct.
module tftpc_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tftpc_pkg::cfg_write_t  cfg,
    input  logic                   fire,
    input  tftpc_pkg::in_word_t    item,
    output tftpc_pkg::out_word_t   result
);

    // Configuration registers
    logic        transfer_mode_reg;
    logic [31:0] file_length_reg;
    logic [31:0] buffer_base_reg;
    logic [7:0]  retry_limit_reg;
    logic [15:0] proposed_bsize_reg;

    // Transfer state
    tftpc_pkg::phase_t phase_reg, phase_next;
    logic        got_reply_reg, got_reply_next;
    logic [7:0]  timeout_count_reg, timeout_count_next;
    logic [15:0] block_size_reg, block_size_next;
    logic [15:0] last_block_reg, last_block_next;
    logic [31:0] byte_count_reg, byte_count_next;

    // Write-mode slice arithmetic
    logic [31:0] offset;
    logic [31:0] rest;
    logic [15:0] slice_length;
    logic [7:0]  timeout_bumped;
    logic        active;

    assign active         = (phase_reg == tftpc_pkg::PH_ACTIVE);
    assign offset         = {16'd0, item.block_number} * {16'd0, block_size_reg};
    assign rest           = file_length_reg - offset;
    assign slice_length   = (rest < {16'd0, block_size_reg}) ? rest[15:0] : block_size_reg;
    assign timeout_bumped = (timeout_count_reg == 8'hFF) ? timeout_count_reg
                                                         : timeout_count_reg + 8'd1;

    // Decode one event into the result and the next state
    always_comb
    begin
        result             = '0;
        phase_next         = phase_reg;
        got_reply_next     = got_reply_reg;
        timeout_count_next = timeout_count_reg;
        block_size_next    = block_size_reg;
        last_block_next    = last_block_reg;
        byte_count_next    = byte_count_reg;

        case (item.operation)
            tftpc_pkg::OP_START:
            begin
                phase_next         = tftpc_pkg::PH_ACTIVE;
                got_reply_next     = 1'b0;
                timeout_count_next = 8'd0;
                block_size_next    = proposed_bsize_reg;
                last_block_next    = 16'd0;
                byte_count_next    = 32'd0;
                result.send_kind   = tftpc_pkg::SEND_REQ;
            end
            tftpc_pkg::OP_TIMEOUT:
            begin
                if (active)
                begin
                    timeout_count_next = timeout_bumped;
                    if (timeout_bumped >= retry_limit_reg)
                    begin
                        result.finished = 1'b1;
                        result.status   = tftpc_pkg::ST_TIMEOUT;
                        phase_next      = tftpc_pkg::PH_IDLE;
                    end
                    else if (!got_reply_reg)
                    begin
                        result.send_kind = tftpc_pkg::SEND_REQ;
                    end
                end
            end
            tftpc_pkg::OP_PACKET:
            begin
                if (active)
                begin
                    got_reply_next     = 1'b1;
                    timeout_count_next = 8'd0;
                    if (item.packet_opcode == tftpc_pkg::PKT_ACK
                        && transfer_mode_reg == tftpc_pkg::MODE_WRITE)
                    begin
                        if (file_length_reg > offset)
                        begin
                            // Answer only the ACK for the slice last sent
                            if (item.block_number == last_block_reg)
                            begin
                                result.send_kind    = tftpc_pkg::SEND_DATA;
                                result.send_block   = item.block_number + 16'd1;
                                result.send_address = buffer_base_reg + offset;
                                result.send_length  = slice_length;
                                last_block_next     = last_block_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            result.finished = 1'b1;
                            result.status   = tftpc_pkg::ST_OK;
                            phase_next      = tftpc_pkg::PH_IDLE;
                        end
                    end
                    else if (item.packet_opcode == tftpc_pkg::PKT_DATA
                             && transfer_mode_reg == tftpc_pkg::MODE_READ)
                    begin
                        // Store new blocks, acknowledge every one
                        if (item.block_number != last_block_reg)
                        begin
                            result.store_enable  = 1'b1;
                            result.store_address = buffer_base_reg + byte_count_reg;
                            byte_count_next      = byte_count_reg
                                                   + {16'd0, item.payload_length};
                            last_block_next      = item.block_number;
                        end
                        result.send_kind  = tftpc_pkg::SEND_ACK;
                        result.send_block = item.block_number;
                        if (item.payload_length < block_size_reg)
                        begin
                            result.finished = 1'b1;
                            result.status   = tftpc_pkg::ST_OK;
                            phase_next      = tftpc_pkg::PH_IDLE;
                        end
                    end
                    else if (item.packet_opcode == tftpc_pkg::PKT_ERROR)
                    begin
                        result.finished = 1'b1;
                        phase_next      = tftpc_pkg::PH_IDLE;
                        if (item.error_code == tftpc_pkg::ERR_NOT_FOUND)
                        begin
                            result.status = tftpc_pkg::ST_NOT_FOUND;
                        end
                        else if (item.error_code == tftpc_pkg::ERR_DENIED)
                        begin
                            result.status = tftpc_pkg::ST_DENIED;
                        end
                        else
                        begin
                            result.status = tftpc_pkg::ST_OTHER;
                        end
                    end
                    else if (item.packet_opcode == tftpc_pkg::PKT_OACK)
                    begin
                        if (item.option_is_block_size)
                        begin
                            block_size_next = item.option_block_size;
                        end
                        result.send_kind  = tftpc_pkg::SEND_ACK;
                        result.send_block = 16'd0;
                    end
                end
            end
            default:
            begin
                result.send_kind = tftpc_pkg::SEND_NONE;
            end
        endcase

        result.received_length = byte_count_next;
    end

    // Hold configuration; the user must write only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transfer_mode_reg  <= tftpc_pkg::MODE_READ;
            file_length_reg    <= 32'd0;
            buffer_base_reg    <= 32'd0;
            retry_limit_reg    <= tftpc_pkg::RETRY_LIMIT_RESET;
            proposed_bsize_reg <= tftpc_pkg::BLOCK_SIZE_RESET;
        end
        else if (cfg.write)
        begin
            case (cfg.index)
                tftpc_pkg::CFG_TRANSFER_MODE:  transfer_mode_reg  <= cfg.data[0];
                tftpc_pkg::CFG_FILE_LENGTH:    file_length_reg    <= cfg.data;
                tftpc_pkg::CFG_BUFFER_BASE:    buffer_base_reg    <= cfg.data;
                tftpc_pkg::CFG_RETRY_LIMIT:    retry_limit_reg    <= cfg.data[7:0];
                tftpc_pkg::CFG_PROPOSED_BSIZE: proposed_bsize_reg <= cfg.data[15:0];
                default:                       transfer_mode_reg  <= transfer_mode_reg;
            endcase
        end
    end

    // Advance transfer state once per processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= tftpc_pkg::PH_IDLE;
            got_reply_reg     <= 1'b0;
            timeout_count_reg <= 8'd0;
            block_size_reg    <= tftpc_pkg::BLOCK_SIZE_RESET;
            last_block_reg    <= 16'd0;
            byte_count_reg    <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            got_reply_reg     <= got_reply_next;
            timeout_count_reg <= timeout_count_next;
            block_size_reg    <= block_size_next;
            last_block_reg    <= last_block_next;
            byte_count_reg    <= byte_count_next;
        end
    end

    // A finishing event leaves the transfer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.finished) |=> (phase_reg == tftpc_pkg::PH_IDLE))
        else $error("transfer still active after finishing event");

    // A start leaves a fresh active transfer with the proposed block size
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.operation == tftpc_pkg::OP_START) |=>
        (phase_reg == tftpc_pkg::PH_ACTIVE && timeout_count_reg == 8'd0
         && byte_count_reg == 32'd0 && block_size_reg == $past(proposed_bsize_reg)))
        else $error("start did not reload transfer state");

    // Reported length follows the byte counter
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (byte_count_reg == $past(result.received_length)))
        else $error("received length and byte counter disagree");

    // A stored payload is always acknowledged in the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.store_enable) |-> (result.send_kind == tftpc_pkg::SEND_ACK))
        else $error("payload stored without an ACK");

endmodule

>>> hw/rtl/tftpc_out_stage.sv
// Result register of the TFTP client transfer control block.
// Depends on tftpc_pkg for the result word type.
module tftpc_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_ready,
    input  tftpc_pkg::out_word_t  load_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tftpc_pkg::out_word_t  out_word
);

    logic                 valid_reg;
    logic                 valid_next;
    tftpc_pkg::out_word_t word_reg;

    // Free when empty or when the held word leaves this cycle
    assign load_ready = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_word   = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            word_reg <= load_word;
        end
    end

endmodule

>>> hw/rtl/tftp_client_transfer_control.sv
// TFTP client transfer control: one event word in (start, packet header or
// timeout tick), one action word out per event. The block takes one event
// every clock cycle while the result register is not stalled. An accepted
// event is held in the input register while its whole decode runs in a single
// pass into the result register, which then presents its action word. That
// combinational path is led by the 16 x 16 block-number times block-size
// multiply and the 32-bit length compare. A stalled, full result register
// holds the input register, and a further event then sees in_stall.
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them while no event is in flight; the block does not check.
// Depends on tftpc_pkg, tftpc_in_stage, tftpc_engine and tftpc_out_stage.
module tftp_client_transfer_control (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tftpc_pkg::in_word_t   in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tftpc_pkg::out_word_t  out_word
);

    tftpc_pkg::cfg_write_t cfg;
    tftpc_pkg::in_word_t   item;
    tftpc_pkg::out_word_t  result;
    logic                  item_valid;
    logic                  load_ready;
    logic                  fire;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Process the held event when the result register can take it
    assign fire = item_valid && load_ready;

    tftpc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (load_ready)
    );

    tftpc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    tftpc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .load_ready (load_ready),
        .load_word  (result),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule
